[design/arps_pkg.sv]
package arps_pkg;

  // Fixed-point format and coordinate width.
  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 12;

  // Widths fixed by the register map and the pixel format.
  localparam int CENTRE_W = 21;
  localparam int RADIUS_W = 20;
  localparam int SIZE_W   = 13;
  localparam int COLOUR_W = 24;
  localparam int COV_W    = 9;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Derived datapath widths.
  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int ABS_W  = ((POS_W >= CENTRE_W - 1) ? POS_W : CENTRE_W - 1) + 1;
  localparam int DIFF_W = ABS_W + 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  typedef enum logic [2:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_RADIUS_INNER = 3'd2,
    REG_RADIUS_OUTER = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } arps_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOUR_W-1:0]   old_colour;
  } arps_in_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] new_colour;
    logic [COV_W-1:0]    coverage;
  } arps_out_t;

  // Per-pixel data that rides alongside the square root.
  typedef struct packed {
    logic                on_image;
    logic [COLOUR_W-1:0] colour;
  } arps_side_t;

endpackage

[design/antialiased_ring_pixel_shader.sv]
// Antialiased ring pixel shader.
// Each input beat carries one pixel (column, row and 24-bit RGB colour); each
// output beat carries the same pixel's darkened colour and the coverage that
// was applied, in 1/256 units. Results leave in the order pixels arrive, one
// output beat for every input beat.
// The ring centre, both radii and the image size sit in registers on the APB
// port; write them only while no pixel is in flight. pready is tied high.
// The block takes a new pixel every cycle unless in_stall is high. The
// depth is set mostly by the square root, which resolves one bit of the
// 22-bit distance per stage; around it sit the offset, squaring and summing
// stages in front and two coverage stages behind.
// Reset clears all valid bits and the output buffer and restores the registers
// to a zero-radius ring at the origin over a 4096 by 4096 image.
// When the receiver stalls, the result waits in the output register and one
// more beat can be caught in a spare register behind it; once that spare
// register is full the whole pipeline holds and in_stall is raised. in_stall
// comes straight from a flip-flop, so the input side never sees the output
// stall combinationally.
module antialiased_ring_pixel_shader (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arps_pkg::ADDR_W-1:0] paddr,
  input  logic [arps_pkg::DATA_W-1:0] pwdata,
  output logic [arps_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  arps_pkg::arps_in_t          in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output arps_pkg::arps_out_t         out_result
);
  import arps_pkg::*;

  localparam int HALF_FX = 1 << (FRAC_BITS - 1);
  localparam int ONE_FX  = 1 << FRAC_BITS;
  localparam int TERM_W  = ((ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W) + 2;
  localparam int CLAMP_W = FRAC_BITS + 1;
  localparam int COVS_W  = FRAC_BITS + 2;
  localparam int CMP_W   = COORD_BITS + SIZE_W;

  // Clamp a signed length to plus or minus one half pixel.
  function automatic logic signed [CLAMP_W-1:0] clamp_half(input logic signed [TERM_W-1:0] v);
    logic signed [CLAMP_W-1:0] res;
    if (v > TERM_W'(HALF_FX)) begin
      res = CLAMP_W'(HALF_FX);
    end else if (v < TERM_W'(-HALF_FX)) begin
      res = CLAMP_W'(-HALF_FX);
    end else begin
      res = v[CLAMP_W-1:0];
    end
    return res;
  endfunction

  // Configuration registers.
  logic signed [CENTRE_W-1:0] centre_x;
  logic signed [CENTRE_W-1:0] centre_y;
  logic [RADIUS_W-1:0]        radius_inner;
  logic [RADIUS_W-1:0]        radius_outer;
  logic [SIZE_W-1:0]          image_width;
  logic [SIZE_W-1:0]          image_height;

  arps_reg_t reg_sel;
  logic      reg_write;

  assign reg_sel   = arps_reg_t'(paddr[4:2]);
  assign reg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x     <= '0;
      centre_y     <= '0;
      radius_inner <= '0;
      radius_outer <= '0;
      image_width  <= SIZE_W'(4096);
      image_height <= SIZE_W'(4096);
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_CENTRE_X:     centre_x     <= pwdata[CENTRE_W-1:0];
        REG_CENTRE_Y:     centre_y     <= pwdata[CENTRE_W-1:0];
        REG_RADIUS_INNER: radius_inner <= pwdata[RADIUS_W-1:0];
        REG_RADIUS_OUTER: radius_outer <= pwdata[RADIUS_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CENTRE_X:     prdata = DATA_W'(unsigned'(centre_x));
      REG_CENTRE_Y:     prdata = DATA_W'(unsigned'(centre_y));
      REG_RADIUS_INNER: prdata = DATA_W'(radius_inner);
      REG_RADIUS_OUTER: prdata = DATA_W'(radius_outer);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // The whole pipeline moves together; it holds only while the spare output
  // register is occupied, which is a registered condition.
  logic skid_valid;
  logic advance;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  // Stage 1: offset from the ring centre to the pixel centre, and its
  // magnitude. Adding one half is a concatenation since the pixel index is
  // whole.
  logic [POS_W-1:0]         pos_x, pos_y;
  logic signed [DIFF_W-1:0] dx, dy, ndx, ndy;
  logic [ABS_W-1:0]         adx_next, ady_next;
  logic                     on_image_next;

  always_comb begin
    pos_x = {in_pixel.pixel_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
    pos_y = {in_pixel.pixel_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
    dx    = $signed({{(DIFF_W-POS_W){1'b0}}, pos_x})
          - $signed({{(DIFF_W-CENTRE_W){centre_x[CENTRE_W-1]}}, centre_x});
    dy    = $signed({{(DIFF_W-POS_W){1'b0}}, pos_y})
          - $signed({{(DIFF_W-CENTRE_W){centre_y[CENTRE_W-1]}}, centre_y});
    ndx   = -dx;
    ndy   = -dy;
    adx_next = dx[DIFF_W-1] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
    ady_next = dy[DIFF_W-1] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
    on_image_next = (CMP_W'(in_pixel.pixel_x) < CMP_W'(image_width))
                 && (CMP_W'(in_pixel.pixel_y) < CMP_W'(image_height));
  end

  logic                s1_valid;
  logic [ABS_W-1:0]    s1_adx, s1_ady;
  arps_side_t          s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_adx           <= adx_next;
      s1_ady           <= ady_next;
      s1_side.on_image <= on_image_next;
      s1_side.colour   <= in_pixel.old_colour;
    end
  end

  // Stage 2: the two squares.
  logic              s2_valid;
  logic [SQ_W-1:0]   s2_sqx, s2_sqy;
  arps_side_t        s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sqx  <= s1_adx * s1_adx;
      s2_sqy  <= s1_ady * s1_ady;
      s2_side <= s1_side;
    end
  end

  // Stage 3: squared distance.
  logic              s3_valid;
  logic [SUM_W-1:0]  s3_sum;
  arps_side_t        s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sum  <= SUM_W'(s2_sqx) + SUM_W'(s2_sqy);
      s3_side <= s2_side;
    end
  end

  // Truncating square root, one result bit per stage.
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  arps_side_t        sq_side;

  arps_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s3_valid),
    .radicand  (s3_sum),
    .in_side   (s3_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Coverage stage 1: distance to each edge, clamped to half a pixel.
  logic signed [TERM_W-1:0] term_outer, term_inner;

  always_comb begin
    term_outer = $signed(TERM_W'(radius_outer)) - $signed(TERM_W'(sq_root));
    term_inner = $signed(TERM_W'(sq_root)) - $signed(TERM_W'(radius_inner));
  end

  logic                      c1_valid;
  logic signed [CLAMP_W-1:0] c1_outer, c1_inner;
  arps_side_t                c1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (advance) begin
      c1_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_outer <= clamp_half(term_outer);
      c1_inner <= clamp_half(term_inner);
      c1_side  <= sq_side;
    end
  end

  // Coverage stage 2: total coverage, its classification and the amount to
  // take off each channel in 1/256 units.
  logic signed [COVS_W-1:0]   cov;
  logic [FRAC_BITS+7:0]       cov_scaled;
  logic                       cov_none, cov_full;

  always_comb begin
    cov        = COVS_W'(c1_outer) + COVS_W'(c1_inner);
    cov_none   = cov[COVS_W-1] || (cov == '0);
    cov_full   = (cov >= COVS_W'(ONE_FX));
    cov_scaled = {cov[FRAC_BITS-1:0], 8'b0} >> FRAC_BITS;
  end

  logic         c2_valid;
  logic         c2_none, c2_full;
  logic [7:0]   c2_amount;
  arps_side_t   c2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (advance) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c2_none   <= cov_none || !c1_side.on_image;
      c2_full   <= cov_full;
      c2_amount <= cov_scaled[7:0];
      c2_side   <= c1_side;
    end
  end

  // Final colour. Full is black; partial cuts each channel, floored at zero.
  arps_out_t result;
  logic      push;

  always_comb begin
    result.new_colour = c2_side.colour;
    result.coverage   = '0;
    if (c2_none) begin
      result.new_colour = c2_side.colour;
      result.coverage   = '0;
    end else if (c2_full) begin
      result.new_colour = '0;
      result.coverage   = COV_W'(256);
    end else if (c2_side.colour == '0) begin
      result.new_colour = '0;
      result.coverage   = '0;
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        result.new_colour[ch*8 +: 8] = (c2_side.colour[ch*8 +: 8] > c2_amount)
                                     ? (c2_side.colour[ch*8 +: 8] - c2_amount) : 8'd0;
      end
      result.coverage = COV_W'(c2_amount);
    end
  end

  assign push = c2_valid && advance;

  // Output register with one spare register behind it.
  arps_out_t out_data, skid_data;
  logic      out_full;
  logic      pop;

  assign pop = out_full && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || pop) begin
      out_full   <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else begin
      skid_valid <= skid_valid || push;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || pop) begin
      out_data  <= skid_valid ? skid_data : result;
      if (skid_valid) begin
        skid_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

  assign out_valid  = out_full;
  assign out_result = out_data;

endmodule

[design/arps_sqrt.sv]
module arps_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [arps_pkg::SUM_W-1:0] radicand,
  input  arps_pkg::arps_side_t       in_side,
  output logic                       out_valid,
  output logic [arps_pkg::ROOT_W-1:0] root,
  output arps_pkg::arps_side_t       out_side
);
  import arps_pkg::*;

  // One result bit per stage, restoring digit-by-digit method.
  logic [ROOT_W:1]     vld;
  logic [REM_W-1:0]    rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   part [0:ROOT_W];
  logic [PAD_W-1:0]    bits [0:ROOT_W];
  arps_side_t          side [0:ROOT_W];

  assign rem[0]  = '0;
  assign part[0] = '0;
  assign bits[0] = PAD_W'(radicand);
  assign side[0] = in_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:1], in_valid};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign shifted = {rem[k][REM_W-3:0], bits[k][PAD_W-1 -: 2]};
    assign trial   = {part[k], 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? (shifted - trial) : shifted;
        part[k+1] <= {part[k][ROOT_W-2:0], fits};
        bits[k+1] <= {bits[k][PAD_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = part[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

[sim/antialiased_ring_pixel_shader_tb.sv]
`timescale 1ns / 100ps

// Testbench for the antialiased ring pixel shader.
// Pixels are pushed through the input channel with random gaps. Results are
// pulled from the output channel under a randomly toggling stall. Each
// accepted input beat is shaded by a predictor in the scoreboard class. Each
// accepted output beat is checked against the oldest prediction.
module antialiased_ring_pixel_shader_tb;
  import arps_pkg::*;

  // Pipeline depth of the block, used for settling time before register
  // writes and at the end of the run.
  localparam int PIPE_DEPTH  = 28;
  localparam int SETTLE      = PIPE_DEPTH + 12;
  // Cycles without any accepted beat or register write before giving up.
  localparam int STALL_LIMIT = 4000;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  // The scoreboard keeps its own copy of the register file. It turns every
  // accepted pixel into the shaded result that should come out for it.
  class ring_scoreboard;
    longint centre_x, centre_y, radius_inner, radius_outer, width, height;
    arps_out_t pending_shades[$];
    int mismatches;

    function new();
      centre_x     = 0;
      centre_y     = 0;
      radius_inner = 0;
      radius_outer = 0;
      width        = 4096;
      height       = 4096;
      mismatches   = 0;
    endfunction

    // Integer square root, truncating, one result bit per pass.
    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned root, probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v    = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    static function longint clamp_half(longint v);
      longint half;
      half = longint'(1) << (FRAC_BITS - 1);
      if (v > half) return half;
      if (v < -half) return -half;
      return v;
    endfunction

    function void set_reg(arps_reg_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_CENTRE_X:     centre_x = $signed(val[CENTRE_W-1:0]);
        REG_CENTRE_Y:     centre_y = $signed(val[CENTRE_W-1:0]);
        REG_RADIUS_INNER: radius_inner = val[RADIUS_W-1:0];
        REG_RADIUS_OUTER: radius_outer = val[RADIUS_W-1:0];
        REG_IMAGE_WIDTH:  width = val[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height = val[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function arps_out_t shade_pixel(arps_in_t p);
      arps_out_t res;
      longint px, py, dx, dy, ring_dist, cov, amount, ch, one, half;
      one  = longint'(1) << FRAC_BITS;
      half = longint'(1) << (FRAC_BITS - 1);
      px   = p.pixel_x;
      py   = p.pixel_y;
      res.new_colour = p.old_colour;
      res.coverage   = '0;
      if (px >= width || py >= height) return res;
      dx   = (px << FRAC_BITS) + half - centre_x;
      dy   = (py << FRAC_BITS) + half - centre_y;
      ring_dist = longint'(floor_root(longint'(dx * dx + dy * dy)));
      cov  = clamp_half(radius_outer - ring_dist) + clamp_half(ring_dist - radius_inner);
      if (cov <= 0) return res;
      if (cov >= one) begin
        res.new_colour = '0;
        res.coverage   = COV_W'(256);
        return res;
      end
      if (p.old_colour == '0) return res;
      amount = (cov << 8) >> FRAC_BITS;
      for (int k = 0; k < 3; k++) begin
        ch = p.old_colour[8*k +: 8];
        res.new_colour[8*k +: 8] = (ch > amount) ? 8'(ch - amount) : 8'd0;
      end
      res.coverage = COV_W'(amount);
      return res;
    endfunction

    function void note_pixel(arps_in_t p);
      pending_shades.push_back(shade_pixel(p));
    endfunction

    function void check_result(arps_out_t got);
      arps_out_t want;
      if (pending_shades.size() == 0) begin
        $error("result beat with no pixel outstanding: colour %h coverage %0d",
               got.new_colour, got.coverage);
        mismatches++;
        return;
      end
      want = pending_shades.pop_front();
      if (got.new_colour !== want.new_colour) begin
        $error("new_colour: expected %h, got %h", want.new_colour, got.new_colour);
        mismatches++;
      end
      if (got.coverage !== want.coverage) begin
        $error("coverage: expected %0d, got %0d", want.coverage, got.coverage);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_shades.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  arps_in_t            in_pixel;
  logic                out_valid;
  logic                out_stall;
  arps_out_t           out_result;

  ring_scoreboard board;

  // When set, neither side idles: the pipeline runs flat out.
  bit steady;

  // The ring currently programmed, kept here so that stimulus can aim at it.
  int ring_cx, ring_cy, ring_ri, ring_ro;

  int quiet_cycles;

  antialiased_ring_pixel_shader uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    if (pick < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Colours lean towards the interesting ones: black, white, and channels
  // small enough to be floored at zero by a partial coverage.
  function automatic logic [COLOUR_W-1:0] pick_colour();
    case ($urandom_range(9))
      0: return '0;
      1: return 24'hffffff;
      2: return {3'b000, 5'($urandom), 3'b000, 5'($urandom), 3'b000, 5'($urandom)};
      default: return COLOUR_W'($urandom);
    endcase
  endfunction

  function automatic arps_in_t pixel_at(int x, int y, logic [COLOUR_W-1:0] c);
    arps_in_t p;
    p.pixel_x    = COORD_BITS'(x);
    p.pixel_y    = COORD_BITS'(y);
    p.old_colour = c;
    return p;
  endfunction

  // Most pixels are aimed at a random point near the ring's edge so that the
  // partial, full and no-coverage outcomes all turn up often. The rest are
  // uniform over the whole coordinate range.
  function automatic arps_in_t pick_pixel();
    int lo, hi, rad, dx, dy, x, y;
    if ($urandom_range(99) >= 75)
      return pixel_at($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), pick_colour());
    lo = ((ring_ri < ring_ro) ? ring_ri : ring_ro) / 256 - 1;
    hi = ((ring_ri < ring_ro) ? ring_ro : ring_ri) / 256 + 1;
    if (lo < 0) lo = 0;
    rad = $urandom_range(hi, lo);
    dx  = int'($urandom_range(2 * rad)) - rad;
    dy  = int'(ring_scoreboard::floor_root(longint'(rad) * rad - longint'(dx) * dx));
    if ($urandom_range(1)) dy = -dy;
    x = (ring_cx >>> FRAC_BITS) + dx + int'($urandom_range(2)) - 1;
    y = (ring_cy >>> FRAC_BITS) + dy + int'($urandom_range(2)) - 1;
    if (x < 0 || x > COORD_MAX) x = $urandom_range(COORD_MAX);
    if (y < 0 || y > COORD_MAX) y = $urandom_range(COORD_MAX);
    return pixel_at(x, y, pick_colour());
  endfunction

  // One register write: a setup cycle, then an access cycle that completes at
  // the edge where pready is seen high.
  task automatic apb_write(arps_reg_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_ring(int cx, int cy, int ri, int ro, int w, int h);
    apb_write(REG_CENTRE_X, DATA_W'(cx));
    apb_write(REG_CENTRE_Y, DATA_W'(cy));
    apb_write(REG_RADIUS_INNER, DATA_W'(ri));
    apb_write(REG_RADIUS_OUTER, DATA_W'(ro));
    apb_write(REG_IMAGE_WIDTH, DATA_W'(w));
    apb_write(REG_IMAGE_HEIGHT, DATA_W'(h));
    ring_cx = cx;
    ring_cy = cy;
    ring_ri = ri;
    ring_ro = ro;
  endtask

  // Presents one pixel, after an optional gap, and returns at the edge where
  // the beat is taken. valid stays high straight into the next beat when
  // there is no gap, so it is never lowered and raised in one step.
  task automatic send_pixel(arps_in_t p);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel());
  endtask

  // Lets every outstanding result arrive, then gives the pipeline time to
  // settle so that the registers can safely be rewritten.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Accepted beats on both channels are sampled at the same edge the block
  // uses, so the scoreboard sees exactly the handshakes that took place.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_pixel(in_pixel);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_result);
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stretches of stall of random length between runs without one.
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  end

  initial begin
    int cx, cy, ri, ro, w, h;
    board    = new();
    steady   = 1'b0;
    ring_cx  = 0;
    ring_cy  = 0;
    ring_ri  = 0;
    ring_ro  = 0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight after reset: zero-radius ring at the origin, full image.
    send_pixel(pixel_at(0, 0, 24'hffffff));
    send_pixel(pixel_at(COORD_MAX, COORD_MAX, 24'h000000));
    drain();

    // A ring of radii 10 and 20 pixels about (100, 100) on a 200 by 150
    // image: pixels beyond either edge, in the hole, fully on the ring, on
    // the soft outer edge, an already black pixel and channels that floor.
    program_ring(100 * 256, 100 * 256, 10 * 256, 20 * 256, 200, 150);
    send_pixel(pixel_at(200, 50, 24'hffffff));
    send_pixel(pixel_at(50, 150, 24'hffffff));
    send_pixel(pixel_at(COORD_MAX, COORD_MAX, 24'hffffff));
    send_pixel(pixel_at(100, 100, 24'habcdef));
    send_pixel(pixel_at(100, 115, 24'h123456));
    send_pixel(pixel_at(100, 119, 24'hffffff));
    send_pixel(pixel_at(113, 114, 24'h808080));
    send_pixel(pixel_at(100, 119, 24'h000000));
    send_pixel(pixel_at(100, 119, 24'h01f003));
    send_pixel(pixel_at(199, 149, 24'hffffff));
    send_pixel(pixel_at(0, 0, 24'hffffff));
    drain();

    // An image of zero width and height leaves every pixel alone.
    program_ring(100 * 256, 100 * 256, 10 * 256, 20 * 256, 0, 0);
    send_pixel(pixel_at(0, 0, 24'hffffff));
    send_pixel(pixel_at(100, 115, 24'hffffff));
    drain();

    // Inner radius beyond the outer one: the same formula, no special path.
    program_ring(100 * 256, 100 * 256, 20 * 256, 10 * 256, 4096, 4096);
    send_pixel(pixel_at(100, 115, 24'hffffff));
    send_pixel(pixel_at(100, 109, 24'h7f7f7f));
    send_pixel(pixel_at(100, 119, 24'hffffff));
    drain();

    // Register extremes: centre at the most negative and most positive
    // values, radii at zero and at full scale, and a one-pixel image.
    program_ring(-1048576, 1048575, 0, 1048575, 4096, 4096);
    send_pixel(pixel_at(0, COORD_MAX, 24'hffffff));
    send_pixel(pixel_at(COORD_MAX, 0, 24'hffffff));
    run_pixels(60);
    drain();
    program_ring(1048575, -1048576, 1048575, 0, 4096, 4096);
    run_pixels(60);
    drain();
    program_ring(128, 128, 0, 300, 1, 1);
    send_pixel(pixel_at(0, 0, 24'hffffff));
    run_pixels(40);
    drain();

    // Random rings, mostly small and thin so that many pixels land on the
    // soft edges; one phase runs without any idling on either side.
    for (int ph = 0; ph < 7; ph++) begin
      if ($urandom_range(3) == 0) begin
        cx = int'($urandom_range(2097151)) - 1048576;
        cy = int'($urandom_range(2097151)) - 1048576;
      end else begin
        cx = $urandom_range(1048575);
        cy = $urandom_range(1048575);
      end
      ri = ($urandom_range(3) == 0) ? $urandom_range(1048575) : $urandom_range(40 * 256);
      ro = ri + int'($urandom_range(1024)) - 256;
      if (ro < 0) ro = 0;
      if (ro > 1048575) ro = 1048575;
      w = ($urandom_range(2) == 0) ? $urandom_range(4096, 1) : 4096;
      h = ($urandom_range(2) == 0) ? $urandom_range(4096, 1) : 4096;
      program_ring(cx, cy, ri, ro, w, h);
      steady = (ph == 2);
      run_pixels(200);
      drain();
      steady = 1'b0;
    end

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
